// ===== hw/rtl/mbib_pkg.sv =====
// ----------------------------------------------------------------------------
// Mobius inverse / barycentric unit package
// Shared constants, register codes and fixed-point helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package mbib_pkg;

	localparam int FRAC_BITS_DEF   = 24;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int POINT_W         = 32;
	localparam int WEIGHT_W        = 25;
	localparam int WEIGHT_FRAC     = 24;
	localparam int REG_W           = 64;
	localparam int CFG_IDX_W       = 3;
	localparam int WIDE_W          = 66;

	typedef logic signed [WIDE_W-1:0] wide_t;
	typedef logic [WEIGHT_W-1:0] weight_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MOBIUS_A     = 3'd0,
		REG_MOBIUS_B     = 3'd1,
		REG_MOBIUS_C     = 3'd2,
		REG_MOBIUS_D     = 3'd3,
		REG_VERTEX_FIRST = 3'd4,
		REG_VERTEX_SECOND = 3'd5,
		REG_VERTEX_THIRD = 3'd6
	} cfg_reg_t;

	// Saturate a wide signed value to a cw-bit signed range.
	function automatic wide_t sat_w(input wide_t x, input int cw);
		wide_t hi;
		wide_t lo;
		hi = (wide_t'(1) <<< (cw - 1)) - wide_t'(1);
		lo = -hi - wide_t'(1);
		if (x > hi) return hi;
		if (x < lo) return lo;
		return x;
	endfunction

	// Convert a weight with f fraction bits to the 25-bit unsigned Q1.24 output format.
	function automatic weight_t to_q24(input wide_t w, input int f);
		logic [WIDE_W-1:0] u;
		u = w;
		if (f >= WEIGHT_FRAC) u = u >> (f - WEIGHT_FRAC);
		else u = u << (WEIGHT_FRAC - f);
		return u[WEIGHT_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mbib_if.sv =====
// ----------------------------------------------------------------------------
// Mobius inverse / barycentric unit channels
// Valid/ready channels for pixel input, result output and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbib_pixel_if;
	logic valid;
	logic ready;
	logic signed [mbib_pkg::POINT_W-1:0] point_re;
	logic signed [mbib_pkg::POINT_W-1:0] point_im;
	modport source (output valid, output point_re, output point_im, input ready);
	modport sink (input valid, input point_re, input point_im, output ready);
endinterface

interface mbib_result_if;
	logic valid;
	logic ready;
	logic [mbib_pkg::WEIGHT_W-1:0] weight_u;
	logic [mbib_pkg::WEIGHT_W-1:0] weight_v;
	logic [mbib_pkg::WEIGHT_W-1:0] weight_w;
	logic outside;
	logic degenerate;
	modport source (output valid, output weight_u, output weight_v, output weight_w,
		output outside, output degenerate, input ready);
	modport sink (input valid, input weight_u, input weight_v, input weight_w,
		input outside, input degenerate, output ready);
endinterface

interface mbib_cfg_if;
	logic valid;
	logic ready;
	logic [mbib_pkg::CFG_IDX_W-1:0] index;
	logic [mbib_pkg::REG_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mbib_fmul.sv =====
// ----------------------------------------------------------------------------
// Registered fixed-point multiplier
// Exact signed product, floored to F fraction bits, saturated to CW bits.
// ----------------------------------------------------------------------------
`default_nettype none

module mbib_fmul #(
	parameter int CW = mbib_pkg::COORD_WIDTH_DEF,
	parameter int F  = mbib_pkg::FRAC_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic signed [CW-1:0] a,
	input  wire logic signed [CW-1:0] b,
	output logic signed [CW-1:0]      prod_s1
);

	logic signed [2*CW-1:0] prod;

	// An arithmetic shift floors toward minus infinity.
	assign prod = a * b;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= CW'(mbib_pkg::sat_w(mbib_pkg::wide_t'(prod >>> F), CW));
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/mbib_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined fixed-point divider
// Two numerators over one shared divisor, one quotient bit per stage,
// quotient (n * 2^F) / d truncated toward zero and saturated to CW bits.
// ----------------------------------------------------------------------------
`default_nettype none

module mbib_div #(
	parameter int CW  = mbib_pkg::COORD_WIDTH_DEF,
	parameter int F   = mbib_pkg::FRAC_BITS_DEF,
	parameter int SBW = 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_valid,
	input  wire logic signed [CW-1:0] num_a,
	input  wire logic signed [CW-1:0] num_b,
	input  wire logic signed [CW-1:0] den,
	input  wire logic [SBW-1:0]       sb_in,
	output logic                      out_valid,
	output logic signed [CW-1:0]      quo_a,
	output logic signed [CW-1:0]      quo_b,
	output logic [SBW-1:0]            sb_out
);

	localparam int NW = CW + F;
	localparam int NS = NW + 1;

	typedef logic [CW-1:0] mag_t;
	typedef logic [NW-1:0] dvd_t;

	logic           v_s[NS];
	mag_t           rem_a_s[NS];
	mag_t           rem_b_s[NS];
	mag_t           dsr_s[NS];
	dvd_t           dvd_a_s[NS];
	dvd_t           dvd_b_s[NS];
	dvd_t           quo_a_s[NS];
	dvd_t           quo_b_s[NS];
	logic           neg_a_s[NS];
	logic           neg_b_s[NS];
	logic [SBW-1:0] sb_s[NS];

	function automatic mag_t mag(input logic signed [CW-1:0] x);
		return x[CW-1] ? mag_t'(-x) : mag_t'(x);
	endfunction

	// Apply the sign and saturate the final magnitude.
	function automatic logic signed [CW-1:0] finish(input dvd_t q, input logic neg);
		mbib_pkg::wide_t m;
		m = mbib_pkg::wide_t'({1'b0, q});
		if (neg) m = -m;
		return CW'(mbib_pkg::sat_w(m, CW));
	endfunction

	// Valid bits travel with the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NS; k++) v_s[k] <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int k = 0; k < NW; k++) v_s[k+1] <= v_s[k];
			out_valid <= v_s[NS-1];
		end
	end

	// Operand capture, one restoring step per stage, then sign and saturation.
	always_ff @(posedge clk) begin
		logic [CW:0] ta;
		logic [CW:0] tb;
		if (en) begin
			rem_a_s[0] <= '0;
			rem_b_s[0] <= '0;
			dsr_s[0]   <= mag(den);
			dvd_a_s[0] <= dvd_t'(mag(num_a)) << F;
			dvd_b_s[0] <= dvd_t'(mag(num_b)) << F;
			quo_a_s[0] <= '0;
			quo_b_s[0] <= '0;
			neg_a_s[0] <= num_a[CW-1] ^ den[CW-1];
			neg_b_s[0] <= num_b[CW-1] ^ den[CW-1];
			sb_s[0]    <= sb_in;
			for (int k = 0; k < NW; k++) begin
				ta = {rem_a_s[k], dvd_a_s[k][NW-1]};
				tb = {rem_b_s[k], dvd_b_s[k][NW-1]};
				if (ta >= {1'b0, dsr_s[k]}) begin
					rem_a_s[k+1] <= CW'(ta - {1'b0, dsr_s[k]});
					quo_a_s[k+1] <= {quo_a_s[k][NW-2:0], 1'b1};
				end else begin
					rem_a_s[k+1] <= CW'(ta);
					quo_a_s[k+1] <= {quo_a_s[k][NW-2:0], 1'b0};
				end
				if (tb >= {1'b0, dsr_s[k]}) begin
					rem_b_s[k+1] <= CW'(tb - {1'b0, dsr_s[k]});
					quo_b_s[k+1] <= {quo_b_s[k][NW-2:0], 1'b1};
				end else begin
					rem_b_s[k+1] <= CW'(tb);
					quo_b_s[k+1] <= {quo_b_s[k][NW-2:0], 1'b0};
				end
				dsr_s[k+1]   <= dsr_s[k];
				dvd_a_s[k+1] <= dvd_a_s[k] << 1;
				dvd_b_s[k+1] <= dvd_b_s[k] << 1;
				neg_a_s[k+1] <= neg_a_s[k];
				neg_b_s[k+1] <= neg_b_s[k];
				sb_s[k+1]    <= sb_s[k];
			end
			quo_a  <= finish(quo_a_s[NS-1], neg_a_s[NS-1]);
			quo_b  <= finish(quo_b_s[NS-1], neg_b_s[NS-1]);
			sb_out <= sb_s[NS-1];
		end
	end

	// The partial remainder stays below a nonzero divisor.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s[NS-1] && dsr_s[NS-1] != '0) |->
		(rem_a_s[NS-1] < dsr_s[NS-1] && rem_b_s[NS-1] < dsr_s[NS-1]))
		else $error("divider remainder not below divisor");

	// A valid last step produces a valid quotient in the next cycle.
	a_last_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s[NS-1]) |=> out_valid)
		else $error("divider lost a beat");

	// A stall freezes the quotient.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(out_valid) && $stable(quo_a) && $stable(quo_b)))
		else $error("divider output moved during stall");

endmodule

`default_nettype wire

// ===== hw/rtl/mobius_inverse_planar_barycentric_unit.sv =====
// ----------------------------------------------------------------------------
// Mobius inverse / barycentric unit
// Maps each pixel point through the inverse Mobius transform and returns its
// barycentric weights against a configured triangle.
// ----------------------------------------------------------------------------
// The whole pipeline advances together and holds while a result beat waits
// unaccepted; while it advances, the unit accepts one pixel beat per clock
// and returns one result beat per pixel, in order. The default coordinate
// format is Q8.24; the depth is set by the two bit-per-stage dividers, one
// for the Mobius quotient and one for the barycentric weights. Registers
// must be written by the user only while the unit is empty; the unit does
// not enforce this. Triangle-derived values settle after a write.
`default_nettype none

module mobius_inverse_planar_barycentric_unit #(
	parameter int FRAC_BITS   = mbib_pkg::FRAC_BITS_DEF,
	parameter int COORD_WIDTH = mbib_pkg::COORD_WIDTH_DEF
) (
	input wire logic     clk,
	input wire logic     arst_n,
	mbib_pixel_if.sink   pixel,
	mbib_result_if.source result,
	mbib_cfg_if.sink     cfg
);

	localparam int CW = COORD_WIDTH;
	localparam int F  = FRAC_BITS;

	typedef logic signed [CW-1:0] coord_t;

	localparam mbib_pkg::wide_t ONE_W = mbib_pkg::sat_w(mbib_pkg::wide_t'(1) <<< F, CW);
	localparam coord_t ONE = coord_t'(ONE_W);
	localparam mbib_pkg::weight_t ONE_Q = mbib_pkg::to_q24(ONE_W, F);

	function automatic coord_t sadd(input coord_t a, input coord_t b);
		return coord_t'(mbib_pkg::sat_w(mbib_pkg::wide_t'(a) + mbib_pkg::wide_t'(b), CW));
	endfunction

	function automatic coord_t ssub(input coord_t a, input coord_t b);
		return coord_t'(mbib_pkg::sat_w(mbib_pkg::wide_t'(a) - mbib_pkg::wide_t'(b), CW));
	endfunction

	function automatic coord_t hi_half(input logic [mbib_pkg::REG_W-1:0] r);
		return coord_t'(mbib_pkg::sat_w(mbib_pkg::wide_t'($signed(r[63:32])), CW));
	endfunction

	function automatic coord_t lo_half(input logic [mbib_pkg::REG_W-1:0] r);
		return coord_t'(mbib_pkg::sat_w(mbib_pkg::wide_t'($signed(r[31:0])), CW));
	endfunction

	logic [mbib_pkg::REG_W-1:0] mobius_a_q, mobius_b_q, mobius_c_q, mobius_d_q;
	logic [mbib_pkg::REG_W-1:0] vertex_first_q, vertex_second_q, vertex_third_q;

	// Register writes.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mobius_a_q      <= '0;
			mobius_b_q      <= '0;
			mobius_c_q      <= '0;
			mobius_d_q      <= '0;
			vertex_first_q  <= '0;
			vertex_second_q <= '0;
			vertex_third_q  <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (mbib_pkg::cfg_reg_t'(cfg.index))
				mbib_pkg::REG_MOBIUS_A:      mobius_a_q      <= cfg.data;
				mbib_pkg::REG_MOBIUS_B:      mobius_b_q      <= cfg.data;
				mbib_pkg::REG_MOBIUS_C:      mobius_c_q      <= cfg.data;
				mbib_pkg::REG_MOBIUS_D:      mobius_d_q      <= cfg.data;
				mbib_pkg::REG_VERTEX_FIRST:  vertex_first_q  <= cfg.data;
				mbib_pkg::REG_VERTEX_SECOND: vertex_second_q <= cfg.data;
				mbib_pkg::REG_VERTEX_THIRD:  vertex_third_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	coord_t ma_re, ma_im, mb_re, mb_im, mc_re, mc_im, md_re, md_im, vi_re, vi_im;

	assign ma_re = hi_half(mobius_a_q);
	assign ma_im = lo_half(mobius_a_q);
	assign mb_re = hi_half(mobius_b_q);
	assign mb_im = lo_half(mobius_b_q);
	assign mc_re = hi_half(mobius_c_q);
	assign mc_im = lo_half(mobius_c_q);
	assign md_re = hi_half(mobius_d_q);
	assign md_im = lo_half(mobius_d_q);
	assign vi_re = hi_half(vertex_first_q);
	assign vi_im = lo_half(vertex_first_q);

	// Triangle terms depend only on registers, so they run in a free pipeline.
	coord_t v0x_q, v0y_q, v1x_q, v1y_q;
	coord_t p00a, p00b, p01a, p01b, p11a, p11b;
	coord_t d00_q, d01_q, d11_q;
	coord_t pdd, pdo;
	coord_t denom_q;
	logic   denom_zero_q;

	always_ff @(posedge clk) begin
		v0x_q <= ssub(hi_half(vertex_second_q), vi_re);
		v0y_q <= ssub(lo_half(vertex_second_q), vi_im);
		v1x_q <= ssub(hi_half(vertex_third_q), vi_re);
		v1y_q <= ssub(lo_half(vertex_third_q), vi_im);
	end

	mbib_fmul #(.CW(CW), .F(F)) u_p00a (.clk, .en(1'b1), .a(v0x_q), .b(v0x_q), .prod_s1(p00a));
	mbib_fmul #(.CW(CW), .F(F)) u_p00b (.clk, .en(1'b1), .a(v0y_q), .b(v0y_q), .prod_s1(p00b));
	mbib_fmul #(.CW(CW), .F(F)) u_p01a (.clk, .en(1'b1), .a(v0x_q), .b(v1x_q), .prod_s1(p01a));
	mbib_fmul #(.CW(CW), .F(F)) u_p01b (.clk, .en(1'b1), .a(v0y_q), .b(v1y_q), .prod_s1(p01b));
	mbib_fmul #(.CW(CW), .F(F)) u_p11a (.clk, .en(1'b1), .a(v1x_q), .b(v1x_q), .prod_s1(p11a));
	mbib_fmul #(.CW(CW), .F(F)) u_p11b (.clk, .en(1'b1), .a(v1y_q), .b(v1y_q), .prod_s1(p11b));

	always_ff @(posedge clk) begin
		d00_q <= sadd(p00a, p00b);
		d01_q <= sadd(p01a, p01b);
		d11_q <= sadd(p11a, p11b);
	end

	mbib_fmul #(.CW(CW), .F(F)) u_pdd (.clk, .en(1'b1), .a(d00_q), .b(d11_q), .prod_s1(pdd));
	mbib_fmul #(.CW(CW), .F(F)) u_pdo (.clk, .en(1'b1), .a(d01_q), .b(d01_q), .prod_s1(pdo));

	always_ff @(posedge clk) begin
		denom_q      <= ssub(pdd, pdo);
		denom_zero_q <= (ssub(pdd, pdo) == '0);
	end

	// Global advance: the pipe moves unless a result beat is stuck.
	logic en;
	logic out_vld_q;

	assign en          = !out_vld_q || result.ready;
	assign pixel.ready = en;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic vd1, vd2;

	// Stage 1: input capture.
	coord_t zre_s1, zim_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			zre_s1 <= coord_t'(mbib_pkg::sat_w(mbib_pkg::wide_t'(pixel.point_re), CW));
			zim_s1 <= coord_t'(mbib_pkg::sat_w(mbib_pkg::wide_t'(pixel.point_im), CW));
		end
	end

	// Stage 2: the eight products of d*z and c*z.
	coord_t dz_rr_s2, dz_ii_s2, dz_ri_s2, dz_ir_s2, cz_rr_s2, cz_ii_s2, cz_ri_s2, cz_ir_s2;

	mbib_fmul #(.CW(CW), .F(F)) u_dz_rr (.clk, .en, .a(md_re), .b(zre_s1), .prod_s1(dz_rr_s2));
	mbib_fmul #(.CW(CW), .F(F)) u_dz_ii (.clk, .en, .a(md_im), .b(zim_s1), .prod_s1(dz_ii_s2));
	mbib_fmul #(.CW(CW), .F(F)) u_dz_ri (.clk, .en, .a(md_re), .b(zim_s1), .prod_s1(dz_ri_s2));
	mbib_fmul #(.CW(CW), .F(F)) u_dz_ir (.clk, .en, .a(md_im), .b(zre_s1), .prod_s1(dz_ir_s2));
	mbib_fmul #(.CW(CW), .F(F)) u_cz_rr (.clk, .en, .a(mc_re), .b(zre_s1), .prod_s1(cz_rr_s2));
	mbib_fmul #(.CW(CW), .F(F)) u_cz_ii (.clk, .en, .a(mc_im), .b(zim_s1), .prod_s1(cz_ii_s2));
	mbib_fmul #(.CW(CW), .F(F)) u_cz_ri (.clk, .en, .a(mc_re), .b(zim_s1), .prod_s1(cz_ri_s2));
	mbib_fmul #(.CW(CW), .F(F)) u_cz_ir (.clk, .en, .a(mc_im), .b(zre_s1), .prod_s1(cz_ir_s2));

	// Stage 3: numerator d*z - b and denominator a - c*z.
	coord_t num_re_s3, num_im_s3, den_re_s3, den_im_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			num_re_s3 <= ssub(ssub(dz_rr_s2, dz_ii_s2), mb_re);
			num_im_s3 <= ssub(sadd(dz_ri_s2, dz_ir_s2), mb_im);
			den_re_s3 <= ssub(ma_re, ssub(cz_rr_s2, cz_ii_s2));
			den_im_s3 <= ssub(ma_im, sadd(cz_ri_s2, cz_ir_s2));
		end
	end

	// Stage 4: products for |den|^2 and num * conj(den).
	coord_t qrr_s4, qii_s4, nrdr_s4, nidi_s4, nidr_s4, nrdi_s4;

	mbib_fmul #(.CW(CW), .F(F)) u_qrr (.clk, .en, .a(den_re_s3), .b(den_re_s3), .prod_s1(qrr_s4));
	mbib_fmul #(.CW(CW), .F(F)) u_qii (.clk, .en, .a(den_im_s3), .b(den_im_s3), .prod_s1(qii_s4));
	mbib_fmul #(.CW(CW), .F(F)) u_nrdr (.clk, .en, .a(num_re_s3), .b(den_re_s3), .prod_s1(nrdr_s4));
	mbib_fmul #(.CW(CW), .F(F)) u_nidi (.clk, .en, .a(num_im_s3), .b(den_im_s3), .prod_s1(nidi_s4));
	mbib_fmul #(.CW(CW), .F(F)) u_nidr (.clk, .en, .a(num_im_s3), .b(den_re_s3), .prod_s1(nidr_s4));
	mbib_fmul #(.CW(CW), .F(F)) u_nrdi (.clk, .en, .a(num_re_s3), .b(den_im_s3), .prod_s1(nrdi_s4));

	// Stage 5: divider operands and the zero-denominator flag.
	coord_t dd_s5, pnr_s5, pni_s5;
	logic   ddz_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			dd_s5  <= sadd(qrr_s4, qii_s4);
			ddz_s5 <= (sadd(qrr_s4, qii_s4) == '0);
			pnr_s5 <= sadd(nrdr_s4, nidi_s4);
			pni_s5 <= ssub(nidr_s4, nrdi_s4);
		end
	end

	// Mobius quotient.
	coord_t p_re, p_im;
	logic   deg1;

	mbib_div #(.CW(CW), .F(F), .SBW(1)) u_div_mobius (
		.clk, .arst_n, .en,
		.in_valid(v_s5), .num_a(pnr_s5), .num_b(pni_s5), .den(dd_s5), .sb_in(ddz_s5),
		.out_valid(vd1), .quo_a(p_re), .quo_b(p_im), .sb_out(deg1)
	);

	// Stage 6: point relative to the first vertex.
	coord_t v2x_s6, v2y_s6;
	logic   deg_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			v2x_s6 <= ssub(p_re, vi_re);
			v2y_s6 <= ssub(p_im, vi_im);
			deg_s6 <= deg1;
		end
	end

	// Stage 7: dot-product terms.
	coord_t t20a_s7, t20b_s7, t21a_s7, t21b_s7;
	logic   deg_s7;

	mbib_fmul #(.CW(CW), .F(F)) u_t20a (.clk, .en, .a(v2x_s6), .b(v0x_q), .prod_s1(t20a_s7));
	mbib_fmul #(.CW(CW), .F(F)) u_t20b (.clk, .en, .a(v2y_s6), .b(v0y_q), .prod_s1(t20b_s7));
	mbib_fmul #(.CW(CW), .F(F)) u_t21a (.clk, .en, .a(v2x_s6), .b(v1x_q), .prod_s1(t21a_s7));
	mbib_fmul #(.CW(CW), .F(F)) u_t21b (.clk, .en, .a(v2y_s6), .b(v1y_q), .prod_s1(t21b_s7));

	// Stage 8: d20 and d21.
	coord_t d20_s8, d21_s8;
	logic   deg_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			deg_s7 <= deg_s6;
			d20_s8 <= sadd(t20a_s7, t20b_s7);
			d21_s8 <= sadd(t21a_s7, t21b_s7);
			deg_s8 <= deg_s7;
		end
	end

	// Stage 9: Cramer products.
	coord_t m1_s9, m2_s9, m3_s9, m4_s9;
	logic   deg_s9;

	mbib_fmul #(.CW(CW), .F(F)) u_m1 (.clk, .en, .a(d11_q), .b(d20_s8), .prod_s1(m1_s9));
	mbib_fmul #(.CW(CW), .F(F)) u_m2 (.clk, .en, .a(d01_q), .b(d21_s8), .prod_s1(m2_s9));
	mbib_fmul #(.CW(CW), .F(F)) u_m3 (.clk, .en, .a(d00_q), .b(d21_s8), .prod_s1(m3_s9));
	mbib_fmul #(.CW(CW), .F(F)) u_m4 (.clk, .en, .a(d01_q), .b(d20_s8), .prod_s1(m4_s9));

	// Stage 10: weight numerators.
	coord_t vn_s10, wn_s10;
	logic   deg_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			deg_s9  <= deg_s8;
			vn_s10  <= ssub(m1_s9, m2_s9);
			wn_s10  <= ssub(m3_s9, m4_s9);
			deg_s10 <= deg_s9;
		end
	end

	// Barycentric quotient.
	coord_t wt_v, wt_w;
	logic   deg2;

	mbib_div #(.CW(CW), .F(F), .SBW(1)) u_div_bary (
		.clk, .arst_n, .en,
		.in_valid(v_s10), .num_a(vn_s10), .num_b(wn_s10), .den(denom_q), .sb_in(deg_s10),
		.out_valid(vd2), .quo_a(wt_v), .quo_b(wt_w), .sb_out(deg2)
	);

	// Valid bits for the stages outside the dividers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			v_s7      <= 1'b0;
			v_s8      <= 1'b0;
			v_s9      <= 1'b0;
			v_s10     <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			v_s1      <= pixel.valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_s5      <= v_s4;
			v_s6      <= vd1;
			v_s7      <= v_s6;
			v_s8      <= v_s7;
			v_s9      <= v_s8;
			v_s10     <= v_s9;
			out_vld_q <= vd2;
		end
	end

	// Final weight, flag resolution and output register.
	coord_t wt_u;
	logic   deg_any, outside_any;

	assign wt_u        = ssub(ssub(ONE, wt_v), wt_w);
	assign deg_any     = deg2 || denom_zero_q;
	assign outside_any = !deg_any && (wt_u[CW-1] || wt_v[CW-1] || wt_w[CW-1]);

	mbib_pkg::weight_t wu_q, wv_q, ww_q;
	logic              outside_q, degenerate_q;

	always_ff @(posedge clk) begin
		if (en) begin
			degenerate_q <= deg_any;
			outside_q    <= outside_any;
			if (deg_any || outside_any) begin
				wu_q <= ONE_Q;
				wv_q <= ONE_Q;
				ww_q <= ONE_Q;
			end else begin
				wu_q <= mbib_pkg::to_q24(mbib_pkg::wide_t'(wt_u), F);
				wv_q <= mbib_pkg::to_q24(mbib_pkg::wide_t'(wt_v), F);
				ww_q <= mbib_pkg::to_q24(mbib_pkg::wide_t'(wt_w), F);
			end
		end
	end

	assign result.valid      = out_vld_q;
	assign result.weight_u   = wu_q;
	assign result.weight_v   = wv_q;
	assign result.weight_w   = ww_q;
	assign result.outside    = outside_q;
	assign result.degenerate = degenerate_q;

	// The two flags are exclusive.
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.outside && result.degenerate))
		else $error("outside and degenerate both set");

	// A flagged result carries unit weights.
	a_flag_ones: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (result.outside || result.degenerate)) |->
		(result.weight_u == ONE_Q && result.weight_v == ONE_Q && result.weight_w == ONE_Q))
		else $error("flagged result without unit weights");

	// Inside weights never exceed one.
	a_inside_range: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.outside && !result.degenerate) |->
		(result.weight_u <= ONE_Q && result.weight_v <= ONE_Q && result.weight_w <= ONE_Q))
		else $error("inside weight above one");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Mobius inverse / barycentric unit testbench
// Streams pixel points through the unit under several coefficient and
// triangle settings and checks every result beat against a fixed-point
// model of the inverse Mobius map and planar barycentric weights.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

	localparam int FB = mbib_pkg::FRAC_BITS_DEF;
	localparam int CW = mbib_pkg::COORD_WIDTH_DEF;
	localparam int PIPE_CYCLES = 2 * (CW + FB) + 15;
	localparam int RANDOM_ITEMS = 1900;

	typedef struct packed {
		logic [mbib_pkg::WEIGHT_W-1:0] u;
		logic [mbib_pkg::WEIGHT_W-1:0] v;
		logic [mbib_pkg::WEIGHT_W-1:0] w;
		logic outside;
		logic degenerate;
	} weights_t;

	typedef struct packed {
		logic [31:0] re;
		logic [31:0] im;
	} point_t;

	logic clk;
	logic arst_n;
	mbib_pixel_if pixel_ch ();
	mbib_result_if result_ch ();
	mbib_cfg_if cfg_ch ();

	mobius_inverse_planar_barycentric_unit dut (
		.clk(clk), .arst_n(arst_n), .pixel(pixel_ch), .result(result_ch), .cfg(cfg_ch)
	);

	// Register copy used by the predictor.
	logic [63:0] coeff_regs [0:6];
	point_t pending_points [$];
	weights_t expected_weights [$];
	int error_count;
	int result_count;
	int outside_count;
	int degenerate_count;
	int send_gap;
	int recv_gap;

	// ---------------------------------------------------------------- model
	function automatic longint clamp(input longint x);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (CW - 1)) - 1;
		lo = -hi - 1;
		if (x > hi) return hi;
		if (x < lo) return lo;
		return x;
	endfunction

	function automatic longint half_of(input logic [31:0] h);
		return clamp(longint'($signed(h)));
	endfunction

	// Exact product, floored to FB fraction bits; arithmetic shift floors.
	function automatic longint fx_mul(input longint a, input longint b);
		return clamp((a * b) >>> FB);
	endfunction

	function automatic longint fx_div(input longint n, input longint d);
		return clamp((n * (longint'(1) <<< FB)) / d);
	endfunction

	function automatic logic [mbib_pkg::WEIGHT_W-1:0] weight_bits(input longint w);
		logic [63:0] x;
		x = w;
		if (FB >= 24) x = x >> (FB - 24);
		else x = x << (24 - FB);
		return x[mbib_pkg::WEIGHT_W-1:0];
	endfunction

	function automatic weights_t predict_weights(input point_t pt);
		weights_t r;
		longint one, zr, zi, ar, ai, br, bi, cr, ci, dr, di;
		longint ix, iy, jx, jy, kx, ky;
		longint tr, ti, nr, ni, er, ei, dd, pr, pi;
		longint v0x, v0y, v1x, v1y, v2x, v2y, d00, d01, d11, d20, d21, dn, u, v, w;
		one = clamp(longint'(1) <<< FB);
		zr = half_of(pt.re); zi = half_of(pt.im);
		ar = half_of(coeff_regs[mbib_pkg::REG_MOBIUS_A][63:32]);
		ai = half_of(coeff_regs[mbib_pkg::REG_MOBIUS_A][31:0]);
		br = half_of(coeff_regs[mbib_pkg::REG_MOBIUS_B][63:32]);
		bi = half_of(coeff_regs[mbib_pkg::REG_MOBIUS_B][31:0]);
		cr = half_of(coeff_regs[mbib_pkg::REG_MOBIUS_C][63:32]);
		ci = half_of(coeff_regs[mbib_pkg::REG_MOBIUS_C][31:0]);
		dr = half_of(coeff_regs[mbib_pkg::REG_MOBIUS_D][63:32]);
		di = half_of(coeff_regs[mbib_pkg::REG_MOBIUS_D][31:0]);
		ix = half_of(coeff_regs[mbib_pkg::REG_VERTEX_FIRST][63:32]);
		iy = half_of(coeff_regs[mbib_pkg::REG_VERTEX_FIRST][31:0]);
		jx = half_of(coeff_regs[mbib_pkg::REG_VERTEX_SECOND][63:32]);
		jy = half_of(coeff_regs[mbib_pkg::REG_VERTEX_SECOND][31:0]);
		kx = half_of(coeff_regs[mbib_pkg::REG_VERTEX_THIRD][63:32]);
		ky = half_of(coeff_regs[mbib_pkg::REG_VERTEX_THIRD][31:0]);
		r.u = weight_bits(one); r.v = r.u; r.w = r.u;
		r.outside = 1'b0; r.degenerate = 1'b0;
		// Numerator d*z - b and denominator a - c*z.
		tr = clamp(fx_mul(dr, zr) - fx_mul(di, zi));
		ti = clamp(fx_mul(dr, zi) + fx_mul(di, zr));
		nr = clamp(tr - br); ni = clamp(ti - bi);
		tr = clamp(fx_mul(cr, zr) - fx_mul(ci, zi));
		ti = clamp(fx_mul(cr, zi) + fx_mul(ci, zr));
		er = clamp(ar - tr); ei = clamp(ai - ti);
		dd = clamp(fx_mul(er, er) + fx_mul(ei, ei));
		if (dd == 0) begin
			r.degenerate = 1'b1;
			return r;
		end
		pr = fx_div(clamp(fx_mul(nr, er) + fx_mul(ni, ei)), dd);
		pi = fx_div(clamp(fx_mul(ni, er) - fx_mul(nr, ei)), dd);
		// Barycentric weights of the mapped point.
		v0x = clamp(jx - ix); v0y = clamp(jy - iy);
		v1x = clamp(kx - ix); v1y = clamp(ky - iy);
		v2x = clamp(pr - ix); v2y = clamp(pi - iy);
		d00 = clamp(fx_mul(v0x, v0x) + fx_mul(v0y, v0y));
		d01 = clamp(fx_mul(v0x, v1x) + fx_mul(v0y, v1y));
		d11 = clamp(fx_mul(v1x, v1x) + fx_mul(v1y, v1y));
		d20 = clamp(fx_mul(v2x, v0x) + fx_mul(v2y, v0y));
		d21 = clamp(fx_mul(v2x, v1x) + fx_mul(v2y, v1y));
		dn = clamp(fx_mul(d00, d11) - fx_mul(d01, d01));
		if (dn == 0) begin
			r.degenerate = 1'b1;
			return r;
		end
		v = fx_div(clamp(fx_mul(d11, d20) - fx_mul(d01, d21)), dn);
		w = fx_div(clamp(fx_mul(d00, d21) - fx_mul(d01, d20)), dn);
		u = clamp(clamp(one - v) - w);
		if (u < 0 || v < 0 || w < 0) begin
			r.outside = 1'b1;
			return r;
		end
		r.u = weight_bits(u); r.v = weight_bits(v); r.w = weight_bits(w);
		return r;
	endfunction

	// ---------------------------------------------------------------- clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("MISMATCH beat %0d %s: got %0h expected %0h", result_count, what, got, want);
		error_count++;
	endtask

	// Pixel driver: random gap before each beat.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_ch.valid <= 1'b0;
			send_gap <= $urandom_range(0, 18);
		end else if (pixel_ch.valid && !pixel_ch.ready) begin
		end else if (send_gap > 0) begin
			pixel_ch.valid <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (pending_points.size() > 0) begin
			point_t pt;
			pt = pending_points.pop_front();
			expected_weights.push_back(predict_weights(pt));
			pixel_ch.valid <= 1'b1;
			pixel_ch.point_re <= pt.re;
			pixel_ch.point_im <= pt.im;
			send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
		end else begin
			pixel_ch.valid <= 1'b0;
		end
	end

	// Result monitor with random back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				weights_t want;
				if (expected_weights.size() == 0) begin
					$display("MISMATCH result beat with nothing expected");
					error_count++;
				end else begin
					want = expected_weights.pop_front();
					if (result_ch.weight_u !== want.u)
						report_mismatch("weight_u", 32'(result_ch.weight_u), 32'(want.u));
					if (result_ch.weight_v !== want.v)
						report_mismatch("weight_v", 32'(result_ch.weight_v), 32'(want.v));
					if (result_ch.weight_w !== want.w)
						report_mismatch("weight_w", 32'(result_ch.weight_w), 32'(want.w));
					if (result_ch.outside !== want.outside)
						report_mismatch("outside", 32'(result_ch.outside),
							32'(want.outside));
					if (result_ch.degenerate !== want.degenerate)
						report_mismatch("degenerate", 32'(result_ch.degenerate),
							32'(want.degenerate));
					outside_count += int'(want.outside);
					degenerate_count += int'(want.degenerate);
				end
				result_count++;
			end
			if (recv_gap > 0) begin
				result_ch.ready <= 1'b0;
				recv_gap <= recv_gap - 1;
			end else begin
				result_ch.ready <= 1'b1;
				if (result_ch.valid && result_ch.ready)
					recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
			end
		end
	end

	// ---------------------------------------------------------------- stimulus
	// One register write; valid is dropped afterwards, so the channel idles between writes.
	task automatic write_reg(input mbib_pkg::cfg_reg_t idx, input logic [63:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		coeff_regs[idx] = value;
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [63:0] pack_q(input real re, input real im);
		logic [31:0] a;
		logic [31:0] b;
		a = $rtoi(re * 16777216.0);
		b = $rtoi(im * 16777216.0);
		return {a, b};
	endfunction

	task automatic drain();
		while (pending_points.size() > 0 || expected_weights.size() > 0 || pixel_ch.valid)
			@(posedge clk);
		repeat (PIPE_CYCLES + 10) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return 32'h7fffffff;
			2: return 32'h80000000;
			default: return 32'($signed($urandom_range(0, 6 << 24)) - (3 << 24));
		endcase
	endfunction

	task automatic random_setting(input bit wild);
		// Mostly a near-identity map with the triangle (-1,-1), (2,-1), (-1,2), sometimes anything.
		if (wild) begin
			for (int r = 0; r < 7; r++)
				write_reg(mbib_pkg::cfg_reg_t'(r), {$urandom, $urandom});
		end else begin
			write_reg(mbib_pkg::REG_MOBIUS_A,
				pack_q(1.0, 0.0) + {$urandom_range(0, 1 << 22), 32'd0});
			write_reg(mbib_pkg::REG_MOBIUS_B,
				{32'($urandom_range(0, 1 << 23)), 32'($urandom_range(0, 1 << 23))});
			write_reg(mbib_pkg::REG_MOBIUS_C,
				{32'($urandom_range(0, 1 << 21)), 32'($urandom_range(0, 1 << 21))});
			write_reg(mbib_pkg::REG_MOBIUS_D,
				pack_q(1.0, 0.0) + {32'($urandom_range(0, 1 << 22)), 32'd0});
			write_reg(mbib_pkg::REG_VERTEX_FIRST, pack_q(-1.0, -1.0));
			write_reg(mbib_pkg::REG_VERTEX_SECOND, pack_q(2.0, -1.0));
			write_reg(mbib_pkg::REG_VERTEX_THIRD, pack_q(-1.0, 2.0));
		end
	endtask

	initial begin
		point_t pt;
		error_count = 0; result_count = 0; outside_count = 0; degenerate_count = 0;
		for (int r = 0; r < 7; r++) coeff_regs[r] = '0;
		cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
		pixel_ch.valid = 1'b0; pixel_ch.point_re = '0; pixel_ch.point_im = '0;
		result_ch.ready = 1'b0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// After reset every point is degenerate.
		pending_points.push_back('{32'h7fffffff, 32'h80000000});
		pending_points.push_back('{32'h0, 32'h0});
		drain();

		// Identity map against a unit triangle: inside, outside, edges, extremes.
		write_reg(mbib_pkg::REG_MOBIUS_A, pack_q(1.0, 0.0));
		write_reg(mbib_pkg::REG_MOBIUS_B, 64'd0);
		write_reg(mbib_pkg::REG_MOBIUS_C, 64'd0);
		write_reg(mbib_pkg::REG_MOBIUS_D, pack_q(1.0, 0.0));
		write_reg(mbib_pkg::REG_VERTEX_FIRST, pack_q(0.0, 0.0));
		write_reg(mbib_pkg::REG_VERTEX_SECOND, pack_q(1.0, 0.0));
		write_reg(mbib_pkg::REG_VERTEX_THIRD, pack_q(0.0, 1.0));
		pending_points.push_back('{32'h00400000, 32'h00400000});
		pending_points.push_back('{32'h0, 32'h0});
		pending_points.push_back('{32'h01000000, 32'h0});
		pending_points.push_back('{32'h0, 32'h01000000});
		pending_points.push_back('{32'h00800000, 32'h00800000});
		pending_points.push_back('{32'hff000000, 32'h00400000});
		pending_points.push_back('{32'h7fffffff, 32'h7fffffff});
		pending_points.push_back('{32'h80000000, 32'h80000000});
		pending_points.push_back('{32'h7fffffff, 32'h80000000});
		pending_points.push_back('{32'hffffffff, 32'h00000001});
		drain();

		// Mobius pole: a - c*z is zero at z = 1 when a = c = 1.
		write_reg(mbib_pkg::REG_MOBIUS_C, pack_q(1.0, 0.0));
		pending_points.push_back('{32'h01000000, 32'h0});
		pending_points.push_back('{32'h00800000, 32'h0});
		drain();

		// Collinear triangle: zero Gram determinant.
		write_reg(mbib_pkg::REG_MOBIUS_C, 64'd0);
		write_reg(mbib_pkg::REG_VERTEX_THIRD, pack_q(2.0, 0.0));
		pending_points.push_back('{32'h00400000, 32'h00400000});
		drain();

		// Register extremes.
		for (int r = 0; r < 7; r++)
			write_reg(mbib_pkg::cfg_reg_t'(r), 64'hffffffffffffffff);
		pending_points.push_back('{32'h01000000, 32'h01000000});
		drain();
		for (int r = 0; r < 7; r++)
			write_reg(mbib_pkg::cfg_reg_t'(r), 64'h7fffffff80000000);
		pending_points.push_back('{32'h00100000, 32'hfff00000});
		drain();

		// Random phases.
		for (int ph = 0; ph < 19; ph++) begin
			random_setting(ph % 4 == 3);
			for (int n = 0; n < RANDOM_ITEMS / 19; n++) begin
				if ($urandom_range(0, 9) == 0) begin
					pt.re = $urandom; pt.im = $urandom;
				end else begin
					pt.re = rand_coord(); pt.im = rand_coord();
				end
				pending_points.push_back(pt);
			end
			drain();
		end

		$display("Checked %0d result beats: %0d outside, %0d degenerate, %0d errors.",
			result_count, outside_count, degenerate_count, error_count);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#(12 * 4000000);
		$display("Timeout with %0d results outstanding", expected_weights.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/mbib_pkg.sv
hw/rtl/mbib_if.sv
hw/rtl/mbib_fmul.sv
hw/rtl/mbib_div.sv
hw/rtl/mobius_inverse_planar_barycentric_unit.sv
bench/tb.sv
